FILE: design/pssv_pkg.sv
// shared constants, register codes and types of the plucked string voice
package pssv_pkg;

   localparam int SAMPLE_BITS_DEF   = 16;
   localparam int HISTORY_DEPTH_DEF = 2048;

   // fixed field widths
   localparam int WHOLE_W  = 11;
   localparam int FRAC_W   = 16;
   localparam int GAIN_W   = 17;
   localparam int COUNT_W  = 24;
   localparam int FRAC_BITS = 16;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [GAIN_W-1:0] UNITY = 17'h10000;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DELAY_WHOLE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELAY_FRACTION = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_COEF    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NOTE_GAIN      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE_GAIN   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_NOTE_LENGTH    = 3'd5;

   // register reset values
   localparam logic [WHOLE_W-1:0] DELAY_WHOLE_RST    = 11'd100;
   localparam logic [FRAC_W-1:0]  DELAY_FRACTION_RST = 16'd0;
   localparam logic [GAIN_W-1:0]  FILTER_COEF_RST    = 17'd32768;
   localparam logic [GAIN_W-1:0]  NOTE_GAIN_RST      = 17'd65000;
   localparam logic [GAIN_W-1:0]  RELEASE_GAIN_RST   = 17'd60000;
   localparam logic [COUNT_W-1:0] NOTE_LENGTH_RST    = 24'd44100;

   // control of the shared multiply-accumulate unit
   typedef struct packed {
      logic enable;
      logic accumulate;
   } mac_ctl_type;

   function automatic logic [GAIN_W-1:0] clamp_unity(input logic [GAIN_W-1:0] g);
      return (g > UNITY) ? UNITY : g;
   endfunction

endpackage

FILE: design/pssv_req_if.sv
// request channel: excitation word and start flag
interface pssv_req_if #(
   parameter int SAMPLE_BITS = pssv_pkg::SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] excitation;
   logic                          start_req;

   modport source (output valid, output excitation, output start_req, input ready);
   modport sink   (input valid, input excitation, input start_req, output ready);
endinterface

FILE: design/pssv_rsp_if.sv
// response channel: output sample and release flag
interface pssv_rsp_if #(
   parameter int SAMPLE_BITS = pssv_pkg::SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          in_release;

   modport source (output valid, output sample, output in_release, input ready);
   modport sink   (input valid, input sample, input in_release, output ready);
endinterface

FILE: design/pssv_ram.sv
// generic single write, single read ram with registered read data
module pssv_ram #(
   parameter int WIDTH = pssv_pkg::SAMPLE_BITS_DEF,
   parameter int DEPTH = pssv_pkg::HISTORY_DEPTH_DEF,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/pssv_mac.sv
// shared signed multiply-accumulate unit with round-half-up output
module pssv_mac #(
   parameter int OP_W  = 18,
   parameter int OUT_W = 18,
   localparam int ACC_W = 2 * OP_W + 1
) (
   input  logic                    clock,
   input  pssv_pkg::mac_ctl_type   ctl,
   input  logic signed [OP_W-1:0]  op_a,
   input  logic signed [OP_W-1:0]  op_b,
   output logic signed [OUT_W-1:0] rounded
);

   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (pssv_pkg::FRAC_BITS - 1);

   logic signed [2*OP_W-1:0] prod;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  rounded_wide;

   assign prod   = op_a * op_b;
   assign acc_in = ctl.accumulate ? acc_ff + ACC_W'(prod) : ACC_W'(prod);

   always_ff @(posedge clock) begin
      if (ctl.enable) begin
         acc_ff <= acc_in;
      end
   end

   // floor of (acc + half) / 2^16
   assign rounded_wide = (acc_ff + HALF) >>> pssv_pkg::FRAC_BITS;
   assign rounded      = rounded_wide[OUT_W-1:0];

endmodule

FILE: design/plucked_string_synth_voice_unit.sv
// plucked string voice: sequencer, history line and shared multiply-accumulate
//
// Usage: each word on req_if carries one excitation sample (signed, Q1.15)
// and a start flag; start_req clears the sample counter before the word is
// processed, history and previous output are kept. Each request word yields
// exactly one word on rsp_if: the saturated output sample and a flag that is
// high when the release gain was applied.
// Configuration: csr_write_en, csr_index and csr_wdata write one register per
// cycle; write only while the voice is idle.
// Timing: req_if.ready is high only while the sequencer is idle. When the
// string feedback is active an item passes through two history reads, five
// multiplies on one multiplier and three rounding steps before the next
// acceptance; otherwise it goes straight to its final step. The response
// shows up in the cycle after its final sequencer step.
// A one-word output register holds the response; the next request is taken
// while it waits, and the sequencer holds in its last step while rsp_if
// stalls with a word still pending.
// Reset (synchronous, active high) loads the register defaults and clears
// counter, previous output and control; the history needs no clearing.
module plucked_string_synth_voice_unit #(
   parameter int HISTORY_DEPTH = pssv_pkg::HISTORY_DEPTH_DEF,
   parameter int SAMPLE_BITS   = pssv_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   pssv_req_if.sink                               req_if,
   pssv_rsp_if.source                             rsp_if,
   input  logic                                   csr_write_en,
   input  logic [pssv_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [pssv_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int AW    = $clog2(HISTORY_DEPTH);
   localparam int VAL_W = SAMPLE_BITS + 2;
   localparam int OP_W  = (VAL_W > pssv_pkg::GAIN_W + 1) ? VAL_W : pssv_pkg::GAIN_W + 1;
   localparam int GW    = pssv_pkg::GAIN_W;
   localparam int CW    = pssv_pkg::COUNT_W;

   localparam logic [AW-1:0]          LAST_ADDR = AW'(HISTORY_DEPTH - 1);
   localparam logic signed [VAL_W:0]  SMAX = (VAL_W + 1)'(2 ** (SAMPLE_BITS - 1) - 1);
   localparam logic signed [VAL_W:0]  SMIN = -SMAX - (VAL_W + 1)'(1);

   typedef enum logic [3:0] {
      S_IDLE, S_READ0, S_MUL0, S_MUL1, S_RND1, S_MUL2, S_RND2,
      S_MUL3, S_MUL4, S_RND3, S_FIN
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [pssv_pkg::WHOLE_W-1:0] delay_whole_ff;
   logic [pssv_pkg::FRAC_W-1:0]  delay_fraction_ff;
   logic [GW-1:0]                filter_coef_ff;
   logic [GW-1:0]                note_gain_ff;
   logic [GW-1:0]                release_gain_ff;
   logic [CW-1:0]                note_length_ff;

   // voice state
   logic [CW-1:0]                 count_ff;
   logic [AW-1:0]                 wr_pos_ff;
   logic signed [SAMPLE_BITS-1:0] prev_ff;

   // per item working registers
   logic signed [SAMPLE_BITS-1:0] exc_ff;
   logic [AW-1:0]                 i0_ff;
   logic [AW-1:0]                 i1_ff;
   logic [pssv_pkg::FRAC_W-1:0]   frac_ff;
   logic [GW-1:0]                 gain_ff;
   logic [GW-1:0]                 coef_ff;
   logic                          rel_ff;
   logic signed [VAL_W-1:0]       val_ff;

   // output register
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic                          rsp_rel_ff;

   logic                  accept;
   logic                  out_free;
   logic [CW-1:0]         pos;
   logic [31:0]           w_wide;
   logic [AW-1:0]         w_eff;
   logic [AW:0]           i0_calc;
   logic                  active;
   logic                  release_now;

   pssv_pkg::mac_ctl_type   mac_ctl;
   logic signed [OP_W-1:0]  op_a;
   logic signed [OP_W-1:0]  op_b;
   logic signed [VAL_W-1:0] mac_rounded;

   logic                          ram_rd_en;
   logic [AW-1:0]                 ram_rd_addr;
   logic [SAMPLE_BITS-1:0]        ram_rd_data;
   logic                          ram_we;
   logic signed [SAMPLE_BITS-1:0] tap;
   logic signed [VAL_W:0]         sum;
   logic signed [SAMPLE_BITS-1:0] sat;

   assign accept   = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == S_IDLE);

   assign pos = req_if.start_req ? '0 : count_ff;

   // period clamped to the usable history
   always_comb begin
      w_wide = 32'(delay_whole_ff);
      if (w_wide < 32'd2) begin
         w_wide = 32'd2;
      end
      if (w_wide > 32'(HISTORY_DEPTH - 1)) begin
         w_wide = 32'(HISTORY_DEPTH - 1);
      end
      w_eff = w_wide[AW-1:0];
   end

   always_comb begin
      if (wr_pos_ff >= w_eff) begin
         i0_calc = {1'b0, wr_pos_ff} - {1'b0, w_eff};
      end else begin
         i0_calc = (AW + 1)'(HISTORY_DEPTH) + {1'b0, wr_pos_ff} - {1'b0, w_eff};
      end
   end

   // older tap is written only once the count passes the whole period
   assign active = (delay_fraction_ff == '0) ? (32'(pos) >= w_wide) : (32'(pos) > w_wide);
   assign release_now = (pos >= note_length_ff);

   // operand selection for the shared multiplier
   assign tap = ram_rd_data;
   always_comb begin
      mac_ctl = '0;
      op_a    = '0;
      op_b    = '0;
      unique case (state_ff)
         S_MUL0: begin
            mac_ctl.enable = 1'b1;
            op_a = OP_W'(tap);
            op_b = OP_W'(pssv_pkg::UNITY - {1'b0, frac_ff});
         end
         S_MUL1: begin
            mac_ctl = '{enable: 1'b1, accumulate: 1'b1};
            op_a = (frac_ff == '0) ? '0 : OP_W'(tap);
            op_b = OP_W'({1'b0, frac_ff});
         end
         S_MUL2: begin
            mac_ctl.enable = 1'b1;
            op_a = OP_W'(val_ff);
            op_b = OP_W'(gain_ff);
         end
         S_MUL3: begin
            mac_ctl.enable = 1'b1;
            op_a = OP_W'(val_ff);
            op_b = OP_W'(coef_ff);
         end
         S_MUL4: begin
            mac_ctl = '{enable: 1'b1, accumulate: 1'b1};
            op_a = OP_W'(prev_ff);
            op_b = OP_W'(pssv_pkg::UNITY - coef_ff);
         end
         default: begin
            mac_ctl = '0;
         end
      endcase
   end

   pssv_mac #(
      .OP_W  (OP_W),
      .OUT_W (VAL_W)
   ) u_mac (
      .clock   (clock),
      .ctl     (mac_ctl),
      .op_a    (op_a),
      .op_b    (op_b),
      .rounded (mac_rounded)
   );

   assign ram_rd_en   = (state_ff == S_READ0) || (state_ff == S_MUL0);
   assign ram_rd_addr = (state_ff == S_READ0) ? i0_ff : i1_ff;
   assign ram_we      = (state_ff == S_FIN) && out_free;

   assign sum = (VAL_W + 1)'(exc_ff) + (VAL_W + 1)'(val_ff);
   always_comb begin
      if (sum > SMAX) begin
         sat = SMAX[SAMPLE_BITS-1:0];
      end else if (sum < SMIN) begin
         sat = SMIN[SAMPLE_BITS-1:0];
      end else begin
         sat = sum[SAMPLE_BITS-1:0];
      end
   end

   pssv_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_pos_ff),
      .wr_data (sat),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept) state_in = active ? S_READ0 : S_FIN;
         S_READ0: state_in = S_MUL0;
         S_MUL0:  state_in = S_MUL1;
         S_MUL1:  state_in = S_RND1;
         S_RND1:  state_in = S_MUL2;
         S_MUL2:  state_in = S_RND2;
         S_RND2:  state_in = S_MUL3;
         S_MUL3:  state_in = S_MUL4;
         S_MUL4:  state_in = S_RND3;
         S_RND3:  state_in = S_FIN;
         S_FIN:   if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         delay_whole_ff    <= pssv_pkg::DELAY_WHOLE_RST;
         delay_fraction_ff <= pssv_pkg::DELAY_FRACTION_RST;
         filter_coef_ff    <= pssv_pkg::FILTER_COEF_RST;
         note_gain_ff      <= pssv_pkg::NOTE_GAIN_RST;
         release_gain_ff   <= pssv_pkg::RELEASE_GAIN_RST;
         note_length_ff    <= pssv_pkg::NOTE_LENGTH_RST;
         count_ff          <= '0;
         wr_pos_ff         <= '0;
         prev_ff           <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_write_en) begin
            unique case (csr_index)
               pssv_pkg::CSR_DELAY_WHOLE:
                  delay_whole_ff <= csr_wdata[pssv_pkg::WHOLE_W-1:0];
               pssv_pkg::CSR_DELAY_FRACTION:
                  delay_fraction_ff <= csr_wdata[pssv_pkg::FRAC_W-1:0];
               pssv_pkg::CSR_FILTER_COEF:  filter_coef_ff  <= csr_wdata[GW-1:0];
               pssv_pkg::CSR_NOTE_GAIN:    note_gain_ff    <= csr_wdata[GW-1:0];
               pssv_pkg::CSR_RELEASE_GAIN: release_gain_ff <= csr_wdata[GW-1:0];
               pssv_pkg::CSR_NOTE_LENGTH:  note_length_ff  <= csr_wdata[CW-1:0];
               default: ;
            endcase
         end

         if (accept) begin
            // counter saturates rather than wrapping
            count_ff <= (pos == '1) ? pos : pos + CW'(1);
         end

         if (ram_we) begin
            wr_pos_ff     <= (wr_pos_ff == LAST_ADDR) ? '0 : wr_pos_ff + AW'(1);
            prev_ff       <= sat;
            rsp_valid_ff  <= 1'b1;
            rsp_sample_ff <= sat;
            rsp_rel_ff    <= rel_ff;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      // datapath registers
      if (accept) begin
         exc_ff  <= req_if.excitation;
         i0_ff   <= i0_calc[AW-1:0];
         frac_ff <= delay_fraction_ff;
         gain_ff <= pssv_pkg::clamp_unity(release_now ? release_gain_ff : note_gain_ff);
         coef_ff <= pssv_pkg::clamp_unity(filter_coef_ff);
         rel_ff  <= active && release_now;
         val_ff  <= '0;
      end
      if (state_ff == S_READ0) begin
         i1_ff <= (i0_ff == '0) ? LAST_ADDR : i0_ff - AW'(1);
      end
      if (state_ff == S_RND1 || state_ff == S_RND2 || state_ff == S_RND3) begin
         val_ff <= mac_rounded;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.sample     = rsp_sample_ff;
   assign rsp_if.in_release = rsp_rel_ff;

   // the sequencer takes no second word right behind the first
   assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_if.ready)
      else $error("request accepted in back-to-back cycles");

   // the word written to the history is the word presented as the response
   assert property (@(posedge clock) disable iff (reset)
      ram_we |=> rsp_if.valid && (rsp_if.sample == $past(sat)))
      else $error("response differs from stored history word");

   // a finished item always leaves a nonzero sample count
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> count_ff != '0)
      else $error("sample count zero after an item");

   // no history write while a response is still pending on a stalled sink
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_if.ready |-> !ram_we)
      else $error("pending response overwritten");

endmodule
